[design/d8rs_pkg.sv]
// ----------------------------------------------------------------------------
// d8rs_pkg
// Shared widths, types, constants and direction helpers of the D8 receiver
// selector.
// ----------------------------------------------------------------------------
package d8rs_pkg;

    localparam int IDX_W   = 20;
    localparam int HGT_W   = 16;
    localparam int DIR_W   = 3;
    localparam int DROP_W  = HGT_W + 1;
    localparam int STEP_W  = 11;
    localparam int WDROP_W = DROP_W + STEP_W;
    localparam int HASH_W  = 64;
    localparam int WORD_W  = 32;
    localparam int GW_W    = 11;
    localparam int SEED_W  = 32;
    localparam int DOM_W   = 8;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_WIDTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HASH_SEED  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIE_DOMAIN = 2'd2;

    localparam logic [GW_W-1:0]   GRID_WIDTH_RST = GW_W'(256);
    localparam logic [SEED_W-1:0] HASH_SEED_RST  = '0;
    localparam logic [DOM_W-1:0]  TIE_DOMAIN_RST = DOM_W'(1);

    localparam int IN_DATA_W  = ((IDX_W + DIR_W + 4 * HGT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((IDX_W + DIR_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [WDROP_W-1:0] STEP_STRAIGHT = WDROP_W'(1000);
    localparam logic signed [WDROP_W-1:0] STEP_DIAGONAL = WDROP_W'(1414);

    localparam logic [WORD_W-1:0] SCR_MUL_1 = 32'h7feb352d;
    localparam logic [WORD_W-1:0] SCR_MUL_2 = 32'h846ca68b;
    localparam logic [WORD_W-1:0] LO_MUL_A  = 32'h27d4eb2f;
    localparam logic [WORD_W-1:0] LO_MUL_B  = 32'h165667b1;
    localparam logic [WORD_W-1:0] LO_MUL_D  = 32'hd3a2646c;
    localparam logic [WORD_W-1:0] HI_MUL_A  = 32'h9e3779b9;
    localparam logic [WORD_W-1:0] HI_MUL_B  = 32'h85ebca6b;
    localparam logic [WORD_W-1:0] HI_MUL_D  = 32'hc2b2ae35;

    localparam logic [DIR_W-1:0] DIR_E    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_SE   = 3'd1;
    localparam logic [DIR_W-1:0] DIR_S    = 3'd2;
    localparam logic [DIR_W-1:0] DIR_SW   = 3'd3;
    localparam logic [DIR_W-1:0] DIR_WEST = 3'd4;
    localparam logic [DIR_W-1:0] DIR_NW   = 3'd5;
    localparam logic [DIR_W-1:0] DIR_N    = 3'd6;
    localparam logic [DIR_W-1:0] DIR_NE   = 3'd7;

    typedef struct packed {
        logic [GW_W-1:0]   grid_width;
        logic [SEED_W-1:0] hash_seed;
        logic [DOM_W-1:0]  tie_domain;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]          to;
        logic [DIR_W-1:0]          dir;
        logic                      elig;
        logic                      last;
        logic signed [WDROP_W-1:0] wf_straight;
        logic signed [WDROP_W-1:0] wf_diagonal;
        logic signed [WDROP_W-1:0] wg_straight;
        logic signed [WDROP_W-1:0] wg_diagonal;
        logic [HASH_W-1:0]         hash;
    } t_item;

    function automatic logic signed [1:0] dir_dx(input logic [DIR_W-1:0] d);
        logic signed [1:0] r;
        unique case (d)
            DIR_E, DIR_SE, DIR_NE:    r = 2'sd1;
            DIR_SW, DIR_WEST, DIR_NW: r = -2'sd1;
            default:                  r = 2'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [1:0] dir_dy(input logic [DIR_W-1:0] d);
        logic signed [1:0] r;
        unique case (d)
            DIR_SE, DIR_S, DIR_SW: r = 2'sd1;
            DIR_NW, DIR_N, DIR_NE: r = -2'sd1;
            default:               r = 2'sd0;
        endcase
        return r;
    endfunction

    function automatic logic is_diagonal(input logic [DIR_W-1:0] d);
        return d[0];
    endfunction

    function automatic logic [WORD_W-1:0] mix_shift(input logic [WORD_W-1:0] v,
                                                    input int sh);
        return v ^ (v >> sh);
    endfunction

endpackage

[design/d8rs_front.sv]
// ----------------------------------------------------------------------------
// d8rs_front
// Registers each request, forms the neighbor index, weighted drops and the
// seeded pair hash over five stages, and pushes the result into the queue.
// ----------------------------------------------------------------------------
module d8rs_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  d8rs_pkg::t_cfg                       i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [d8rs_pkg::IDX_W-1:0]           i_tile_index,
    input  logic [d8rs_pkg::DIR_W-1:0]           i_dir,
    input  logic                                 i_elig,
    input  logic                                 i_last,
    input  logic signed [d8rs_pkg::HGT_W-1:0]    i_center_filled,
    input  logic signed [d8rs_pkg::HGT_W-1:0]    i_center_ground,
    input  logic signed [d8rs_pkg::HGT_W-1:0]    i_neighbor_filled,
    input  logic signed [d8rs_pkg::HGT_W-1:0]    i_neighbor_ground,
    input  logic                                 i_full,
    output logic                                 o_push,
    output d8rs_pkg::t_item                      o_item
);
    import d8rs_pkg::*;

    logic                      adv;

    logic                      r_v1;
    logic [IDX_W-1:0]          r_s1_from;
    logic [DIR_W-1:0]          r_s1_dir;
    logic                      r_s1_elig;
    logic                      r_s1_last;
    logic signed [HGT_W-1:0]   r_s1_cf;
    logic signed [HGT_W-1:0]   r_s1_cg;
    logic signed [HGT_W-1:0]   r_s1_nf;
    logic signed [HGT_W-1:0]   r_s1_ng;

    logic                      r_v2;
    logic [IDX_W-1:0]          r_s2_from;
    logic [IDX_W-1:0]          r_s2_to;
    logic [DIR_W-1:0]          r_s2_dir;
    logic                      r_s2_elig;
    logic                      r_s2_last;
    logic signed [DROP_W-1:0]  r_s2_fd;
    logic signed [DROP_W-1:0]  r_s2_gd;
    logic [IDX_W-1:0]          n_s2_to;
    logic [IDX_W-1:0]          row_off;
    logic [IDX_W-1:0]          col_off;
    logic [IDX_W-1:0]          gw_ext;

    logic                      r_v3;
    t_item                     r_s3;
    t_item                     n_s3;
    logic [WORD_W-1:0]         r_s3_ahi;
    logic [WORD_W-1:0]         r_s3_alo;
    logic [WORD_W-1:0]         r_s3_bhi;
    logic [WORD_W-1:0]         r_s3_blo;
    logic [WORD_W-1:0]         r_s3_dhi;
    logic [WORD_W-1:0]         r_s3_dlo;
    logic [WORD_W-1:0]         a32;
    logic [WORD_W-1:0]         b32;
    logic [WORD_W-1:0]         d32;

    logic                      r_v4;
    t_item                     r_s4;
    logic [WORD_W-1:0]         r_s4_hi;
    logic [WORD_W-1:0]         r_s4_lo;
    logic [WORD_W-1:0]         x_hi;
    logic [WORD_W-1:0]         x_lo;

    logic                      r_v5;
    t_item                     r_s5;
    logic [WORD_W-1:0]         r_s5_hi;
    logic [WORD_W-1:0]         r_s5_lo;

    assign adv     = !r_v5 || !i_full;
    assign o_ready = adv;
    assign o_push  = r_v5 && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // neighbor index, wrapped to the index width
    always_comb begin
        gw_ext = IDX_W'(i_cfg.grid_width);
        unique case (dir_dy(r_s1_dir))
            2'sd1:   row_off = gw_ext;
            -2'sd1:  row_off = IDX_W'(0) - gw_ext;
            default: row_off = '0;
        endcase
        col_off = IDX_W'(dir_dx(r_s1_dir));
        n_s2_to = r_s1_from + row_off + col_off;
    end

    always_comb begin
        a32 = WORD_W'(r_s2_from);
        b32 = WORD_W'(r_s2_to);
        d32 = WORD_W'(i_cfg.tie_domain);
        n_s3             = '0;
        n_s3.to          = r_s2_to;
        n_s3.dir         = r_s2_dir;
        n_s3.elig        = r_s2_elig;
        n_s3.last        = r_s2_last;
        n_s3.wf_straight = WDROP_W'(r_s2_fd) * STEP_STRAIGHT;
        n_s3.wf_diagonal = WDROP_W'(r_s2_fd) * STEP_DIAGONAL;
        n_s3.wg_straight = WDROP_W'(r_s2_gd) * STEP_STRAIGHT;
        n_s3.wg_diagonal = WDROP_W'(r_s2_gd) * STEP_DIAGONAL;
    end

    assign x_hi = mix_shift(i_cfg.hash_seed ^ r_s3_ahi ^ r_s3_bhi ^ r_s3_dhi, 16);
    assign x_lo = mix_shift(i_cfg.hash_seed ^ r_s3_alo ^ r_s3_blo ^ r_s3_dlo, 16);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_from <= i_tile_index;
            r_s1_dir  <= i_dir;
            r_s1_elig <= i_elig;
            r_s1_last <= i_last;
            r_s1_cf   <= i_center_filled;
            r_s1_cg   <= i_center_ground;
            r_s1_nf   <= i_neighbor_filled;
            r_s1_ng   <= i_neighbor_ground;

            r_s2_from <= r_s1_from;
            r_s2_to   <= n_s2_to;
            r_s2_dir  <= r_s1_dir;
            r_s2_elig <= r_s1_elig;
            r_s2_last <= r_s1_last;
            r_s2_fd   <= DROP_W'(r_s1_cf) - DROP_W'(r_s1_nf);
            r_s2_gd   <= DROP_W'(r_s1_cg) - DROP_W'(r_s1_ng);

            r_s3      <= n_s3;
            r_s3_ahi  <= a32 * HI_MUL_A;
            r_s3_alo  <= a32 * LO_MUL_A;
            r_s3_bhi  <= b32 * HI_MUL_B;
            r_s3_blo  <= b32 * LO_MUL_B;
            r_s3_dhi  <= d32 * HI_MUL_D;
            r_s3_dlo  <= d32 * LO_MUL_D;

            r_s4      <= r_s3;
            r_s4_hi   <= x_hi * SCR_MUL_1;
            r_s4_lo   <= x_lo * SCR_MUL_1;

            r_s5      <= r_s4;
            r_s5_hi   <= mix_shift(r_s4_hi, 15) * SCR_MUL_2;
            r_s5_lo   <= mix_shift(r_s4_lo, 15) * SCR_MUL_2;
        end
    end

    always_comb begin
        o_item      = r_s5;
        o_item.hash = {mix_shift(r_s5_hi, 16), mix_shift(r_s5_lo, 16)};
    end

endmodule

[design/d8rs_queue.sv]
// ----------------------------------------------------------------------------
// d8rs_queue
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module d8rs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  d8rs_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output d8rs_pkg::t_item o_item
);
    import d8rs_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[design/d8rs_back.sv]
// ----------------------------------------------------------------------------
// d8rs_back
// Compares each eligible request against the kept best neighbor, updates it
// and emits the receiver choice on the last request of a tile.
// ----------------------------------------------------------------------------
module d8rs_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  d8rs_pkg::t_item                      i_item,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_found,
    output logic [d8rs_pkg::IDX_W-1:0]           o_index,
    output logic [d8rs_pkg::DIR_W-1:0]           o_dir
);
    import d8rs_pkg::*;

    logic                      r_best_valid;
    t_item                     r_best;
    logic                      n_best_valid;
    t_item                     n_best;
    logic                      take;
    logic signed [WDROP_W-1:0] lf;
    logic signed [WDROP_W-1:0] rf;
    logic signed [WDROP_W-1:0] lg;
    logic signed [WDROP_W-1:0] rg;

    logic                      r_out_valid;
    logic                      r_found;
    logic [IDX_W-1:0]          r_index;
    logic [DIR_W-1:0]          r_dir;

    assign o_pop = i_valid && (!i_item.last || !r_out_valid || i_ready);

    always_comb begin
        lf = is_diagonal(r_best.dir) ? i_item.wf_diagonal : i_item.wf_straight;
        rf = is_diagonal(i_item.dir) ? r_best.wf_diagonal : r_best.wf_straight;
        lg = is_diagonal(r_best.dir) ? i_item.wg_diagonal : i_item.wg_straight;
        rg = is_diagonal(i_item.dir) ? r_best.wg_diagonal : r_best.wg_straight;
        if (!r_best_valid) begin
            take = 1'b1;
        end else if (lf != rf) begin
            take = lf > rf;
        end else if (lg != rg) begin
            take = lg > rg;
        end else begin
            take = i_item.hash < r_best.hash;
        end
        n_best_valid = r_best_valid;
        n_best       = r_best;
        if (i_item.elig && take) begin
            n_best_valid = 1'b1;
            n_best       = i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_best_valid <= n_best_valid && !i_item.last;
            end
            if (o_pop && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_best <= n_best;
        end
        if (o_pop && i_item.last) begin
            r_found <= n_best_valid;
            r_index <= n_best_valid ? n_best.to : '0;
            r_dir   <= n_best_valid ? n_best.dir : '0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_found = r_found;
    assign o_index = r_index;
    assign o_dir   = r_dir;

endmodule

[design/d8_receiver_selector_unit.sv]
// ----------------------------------------------------------------------------
// d8_receiver_selector_unit
// D8 receiver choice for one grid tile over a stream of neighbor requests.
// ----------------------------------------------------------------------------
// Result path: front stages, then the queue, then the registered back output.
// Throughput: one request per cycle unless the queue is full; the five-stage
//   hash pipeline feeds a four-entry queue and the back compare-and-keep loop.
// Reset: synchronous, active low; clears pipeline, queue, kept best and output,
//   and loads grid_width 256, hash_seed 0, tie_domain 1.
module d8_receiver_selector_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [d8rs_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [d8rs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tile_index, neighbor_direction, center_filled, center_ground,
    // neighbor_filled, neighbor_ground, zero pad
    input  logic [d8rs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // candidate_eligible
    input  logic [0:0]                          s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // receiver_index, receiver_direction, zero pad
    output logic [d8rs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // receiver_found
    output logic [0:0]                          m_axis_tuser
);
    import d8rs_pkg::*;

    localparam int DIR_LO = IDX_W;
    localparam int CF_LO  = DIR_LO + DIR_W;
    localparam int CG_LO  = CF_LO + HGT_W;
    localparam int NF_LO  = CG_LO + HGT_W;
    localparam int NG_LO  = NF_LO + HGT_W;

    t_cfg              r_cfg;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    t_item             front_item;
    t_item             q_item;
    logic              out_found;
    logic [IDX_W-1:0]  out_index;
    logic [DIR_W-1:0]  out_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width <= GRID_WIDTH_RST;
            r_cfg.hash_seed  <= HASH_SEED_RST;
            r_cfg.tie_domain <= TIE_DOMAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GRID_WIDTH: r_cfg.grid_width <= i_cfg_wdata[GW_W-1:0];
                CFG_HASH_SEED:  r_cfg.hash_seed  <= i_cfg_wdata[SEED_W-1:0];
                CFG_TIE_DOMAIN: r_cfg.tie_domain <= i_cfg_wdata[DOM_W-1:0];
                default: ;
            endcase
        end
    end

    d8rs_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_valid           (s_axis_tvalid),
        .o_ready           (s_axis_tready),
        .i_tile_index      (s_axis_tdata[IDX_W-1:0]),
        .i_dir             (s_axis_tdata[DIR_LO +: DIR_W]),
        .i_elig            (s_axis_tuser[0]),
        .i_last            (s_axis_tlast),
        .i_center_filled   (s_axis_tdata[CF_LO +: HGT_W]),
        .i_center_ground   (s_axis_tdata[CG_LO +: HGT_W]),
        .i_neighbor_filled (s_axis_tdata[NF_LO +: HGT_W]),
        .i_neighbor_ground (s_axis_tdata[NG_LO +: HGT_W]),
        .i_full            (q_full),
        .o_push            (q_push),
        .o_item            (front_item)
    );

    d8rs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    d8rs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_found (out_found),
        .o_index (out_index),
        .o_dir   (out_dir)
    );

    assign m_axis_tdata = OUT_DATA_W'({out_dir, out_index});
    assign m_axis_tuser = out_found;

endmodule

[design/d8rs_checker.sv]
// ----------------------------------------------------------------------------
// d8rs_checker
// Port-level checks of the D8 receiver selector, bound to the top level.
// ----------------------------------------------------------------------------
module d8rs_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [d8rs_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [d8rs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [d8rs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic [0:0]                          s_axis_tuser,
    input  logic                                s_axis_tlast,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [d8rs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic [0:0]                          m_axis_tuser
);
    import d8rs_pkg::*;

    logic [3:0] r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending
                         + 4'((s_axis_tvalid && s_axis_tready && s_axis_tlast) ? 1 : 0)
                         - 4'((m_axis_tvalid && m_axis_tready) ? 1 : 0);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_no_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("no receiver but nonzero index or direction");

    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid || i_cfg_we) |-> !$isunknown({s_axis_tdata, s_axis_tuser,
                                                     s_axis_tlast, i_cfg_addr,
                                                     i_cfg_wdata}))
        else $error("unknown request or register write");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != '0)
        else $error("result without a pending last request");

endmodule

bind d8_receiver_selector_unit d8rs_checker u_checker (.*);
